### hdl/smv_pkg.sv
// ----------------------------------------------------------------------------
// smv_pkg: shared types and constants for the sparse matrix-vector unit
// Field widths, vector store geometry, request kinds and stage control.
// ----------------------------------------------------------------------------
package smv_pkg;

  localparam int VEC_DEPTH = 4096;
  localparam int VEC_AW    = $clog2(VEC_DEPTH);
  localparam int ROW_LIMIT = 65536;
  localparam int ROW_MAX   = (ROW_LIMIT < 65536) ? ROW_LIMIT : 65536;

  localparam int KIND_W = 2;
  localparam int COL_W  = 12;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 64;
  localparam int ROW_W  = 16;
  localparam int CNT_W  = 17;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_NZ    = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  ends_row;
  } stage_ctl_t;

  function automatic logic [VEC_AW-1:0] vec_index(input logic [COL_W-1:0] col);
    return VEC_AW'(col);
  endfunction

endpackage

### hdl/smv_if.sv
// ----------------------------------------------------------------------------
// smv_if: request, result and configuration channels
// Valid/ready channels carrying the unit's payload fields.
// ----------------------------------------------------------------------------
interface smv_in_if import smv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [COL_W-1:0]        column;
  logic signed [VAL_W-1:0] value;
  logic                    ends_row;

  modport source (output valid, kind, column, value, ends_row, input ready);
  modport sink   (input valid, kind, column, value, ends_row, output ready);
endinterface

interface smv_out_if import smv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        row_index;
  logic signed [SUM_W-1:0] row_sum;
  logic                    saturated;

  modport source (output valid, row_index, row_sum, saturated, input ready);
  modport sink   (input valid, row_index, row_sum, saturated, output ready);
endinterface

interface smv_cfg_if import smv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] row_count;

  modport source (output valid, row_count, input ready);
  modport sink   (input valid, row_count, output ready);
endinterface

### hdl/smv_fetch.sv
// ----------------------------------------------------------------------------
// smv_fetch: request register and vector store
// Writes load requests into the store and reads the element for nonzeros.
// ----------------------------------------------------------------------------
module smv_fetch import smv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    req_fire,
  input  logic [KIND_W-1:0]       req_kind,
  input  logic [COL_W-1:0]        req_column,
  input  logic signed [VAL_W-1:0] req_value,
  input  logic                    req_ends_row,
  output stage_ctl_t              s1_ctl,
  output logic signed [VAL_W-1:0] s1_value,
  output logic signed [VAL_W-1:0] s1_elem
);

  logic [VAL_W-1:0] vec_mem [VEC_DEPTH];

  stage_ctl_t              ctl_r, ctl_nxt;
  logic signed [VAL_W-1:0] value_r;
  logic [VAL_W-1:0]        elem_r;
  logic [VEC_AW-1:0]       idx;
  logic                    is_load;

  assign idx     = vec_index(req_column);
  assign is_load = req_fire && (req_kind == KIND_LOAD);

  always_comb begin
    ctl_nxt          = '0;
    ctl_nxt.kind     = KIND_NZ;
    ctl_nxt.ends_row = req_ends_row;
    case (req_kind)
      KIND_NZ: begin
        ctl_nxt.valid = req_fire;
        ctl_nxt.kind  = KIND_NZ;
      end
      KIND_EMPTY: begin
        ctl_nxt.valid = req_fire;
        ctl_nxt.kind  = KIND_EMPTY;
      end
      default: ctl_nxt.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (is_load) begin
      vec_mem[idx] <= req_value;
    end
    if (adv) begin
      elem_r <= vec_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r <= req_value;
    end
  end

  assign s1_ctl   = ctl_r;
  assign s1_value = value_r;
  assign s1_elem  = elem_r;

endmodule

### hdl/smv_mult.sv
// ----------------------------------------------------------------------------
// smv_mult: product stage
// Multiplies the Q16.16 matrix value by the vector element into Q32.32.
// ----------------------------------------------------------------------------
module smv_mult import smv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  stage_ctl_t              s1_ctl,
  input  logic signed [VAL_W-1:0] s1_value,
  input  logic signed [VAL_W-1:0] s1_elem,
  output stage_ctl_t              s2_ctl,
  output logic signed [SUM_W-1:0] s2_prod
);

  stage_ctl_t              ctl_r;
  logic signed [SUM_W-1:0] prod_r, prod_nxt;

  assign prod_nxt = s1_value * s1_elem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  assign s2_ctl  = ctl_r;
  assign s2_prod = prod_r;

endmodule

### hdl/smv_accum.sv
// ----------------------------------------------------------------------------
// smv_accum: row accumulator and result register
// Saturating Q32.32 accumulate, row counter, row count register, result hold.
// ----------------------------------------------------------------------------
module smv_accum import smv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  stage_ctl_t              s2_ctl,
  input  logic signed [SUM_W-1:0] s2_prod,
  input  logic                    cfg_fire,
  input  logic [CNT_W-1:0]        cfg_rows,
  input  logic                    out_ready,
  output logic                    adv,
  output logic                    out_valid,
  output logic [ROW_W-1:0]        out_row_index,
  output logic signed [SUM_W-1:0] out_row_sum,
  output logic                    out_saturated
);

  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic             clip_r, clip_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CNT_W-1:0] rows_r, rows_nxt;
  logic             out_valid_r;
  logic [ROW_W-1:0] row_index_r;
  logic [SUM_W-1:0] row_sum_r;
  logic             sat_r;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_sat;
  logic             ovf;
  logic             fire;
  logic             emit;
  logic [CNT_W-1:0] row_inc;

  assign adv  = !out_valid_r || out_ready;
  assign fire = adv && s2_ctl.valid;

  assign sum = acc_r + s2_prod;
  assign ovf = (s2_ctl.kind == KIND_NZ) && (acc_r[SUM_W-1] == s2_prod[SUM_W-1])
            && (sum[SUM_W-1] != acc_r[SUM_W-1]);

  always_comb begin
    sum_sat = acc_r;
    emit    = 1'b0;
    case (s2_ctl.kind)
      KIND_NZ: begin
        emit = s2_ctl.ends_row;
        if (ovf) begin
          sum_sat = acc_r[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          sum_sat = sum;
        end
      end
      KIND_EMPTY: emit = 1'b1;
      default:    emit = 1'b0;
    endcase
  end

  assign row_inc = {1'b0, row_cnt_r} + CNT_W'(1);

  always_comb begin
    acc_nxt     = acc_r;
    clip_nxt    = clip_r;
    row_cnt_nxt = row_cnt_r;
    if (fire) begin
      if (emit) begin
        acc_nxt     = '0;
        clip_nxt    = 1'b0;
        row_cnt_nxt = (row_inc >= rows_r) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        acc_nxt  = sum_sat;
        clip_nxt = clip_r || ovf;
      end
    end
  end

  always_comb begin
    rows_nxt = cfg_rows;
    if (cfg_rows == '0) begin
      rows_nxt = CNT_W'(1);
    end else if (cfg_rows > CNT_W'(ROW_MAX)) begin
      rows_nxt = CNT_W'(ROW_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      clip_r      <= 1'b0;
      row_cnt_r   <= '0;
      rows_r      <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      clip_r    <= clip_nxt;
      row_cnt_r <= row_cnt_nxt;
      if (cfg_fire) begin
        rows_r <= rows_nxt;
      end
      if (adv) begin
        out_valid_r <= s2_ctl.valid && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      row_index_r <= row_cnt_r;
      row_sum_r   <= sum_sat;
      sat_r       <= clip_r || ovf;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = row_index_r;
  assign out_row_sum   = row_sum_r;
  assign out_saturated = sat_r;

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit) |=> (acc_r == '0) && !clip_r)
    else $error("accumulator not cleared after row result");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit) |=> out_valid_r)
    else $error("row result not presented");

  a_clip_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(clip_r) |-> $past(fire && ovf && !emit))
    else $error("clip flag set without overflow");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(acc_r))
    else $error("accumulator moved while result stalled");

endmodule

### hdl/csr_sparse_matvec_unit.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec_unit: CSR sparse matrix times dense vector
// Loads vector elements, accumulates nonzero products per row, emits row sums.
// ----------------------------------------------------------------------------
//  channel  dir  payload                               transfer
//  in_req   in   kind, column, value, ends_row         valid & ready
//  out_res  out  row_index, row_sum, saturated         valid & ready
//  cfg_wr   in   row_count                             valid & ready
//
//  One request per cycle while no result is stalled; the request that ends a row
//  goes through store read, multiply, then accumulate into the result register.
//  Every stage moves together; all stages hold while a result waits unaccepted.
//  Reset clears accumulator, clip flag, row counter and sets row count to one.
//  Vector store holds no reset state; cfg_wr is always ready.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_unit import smv_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  smv_in_if.sink   in_req,
  smv_out_if.source out_res,
  smv_cfg_if.sink  cfg_wr
);

  logic                    adv;
  logic                    req_fire;
  stage_ctl_t              s1_ctl;
  logic signed [VAL_W-1:0] s1_value;
  logic signed [VAL_W-1:0] s1_elem;
  stage_ctl_t              s2_ctl;
  logic signed [SUM_W-1:0] s2_prod;

  assign in_req.ready = adv;
  assign cfg_wr.ready = 1'b1;
  assign req_fire     = in_req.valid && adv;

  smv_fetch u_fetch (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .req_fire     (req_fire),
    .req_kind     (in_req.kind),
    .req_column   (in_req.column),
    .req_value    (in_req.value),
    .req_ends_row (in_req.ends_row),
    .s1_ctl       (s1_ctl),
    .s1_value     (s1_value),
    .s1_elem      (s1_elem)
  );

  smv_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s1_ctl   (s1_ctl),
    .s1_value (s1_value),
    .s1_elem  (s1_elem),
    .s2_ctl   (s2_ctl),
    .s2_prod  (s2_prod)
  );

  smv_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .s2_ctl        (s2_ctl),
    .s2_prod       (s2_prod),
    .cfg_fire      (cfg_wr.valid),
    .cfg_rows      (cfg_wr.row_count),
    .out_ready     (out_res.ready),
    .adv           (adv),
    .out_valid     (out_res.valid),
    .out_row_index (out_res.row_index),
    .out_row_sum   (out_res.row_sum),
    .out_saturated (out_res.saturated)
  );

endmodule
